### design/mbss_pkg.sv
// Package for the masked byte signature scanner.
// Holds the word types, configuration types, register codes and defaults.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mbss_pkg;

    // Default and largest supported pattern length in bytes.
    localparam int PATTERN_BYTES_DEF = 16;

    // Configuration port geometry: five registers at 8-byte spacing.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_W  = 3;

    // Register indexes (paddr divided by 8).
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 3'd4;

    localparam logic [4:0] PATTERN_LEN_RESET = 5'd1;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        t_byte data_byte;
        logic  last_byte;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic [31:0] match_address;
    } t_out_word;

    typedef struct packed {
        logic [63:0] pattern_low_bytes;
        logic [63:0] pattern_high_bytes;
        logic [15:0] compare_mask;
        logic [4:0]  pattern_length;
        logic [31:0] base_address;
    } t_cfg;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_match_result;

    typedef struct packed {
        logic [31:0] bytes_seen;
        logic        reported;
    } t_match_status;

endpackage

`default_nettype wire

### design/masked_byte_signature_scanner.sv
// Top level of the masked byte signature scanner.
// Instantiates mbss_cfg_regs and mbss_matcher and holds the result register.
//
// Usage: region bytes arrive as words on the input channel (i_in_valid,
// o_in_ready, i_in_word), one byte per word, with last_byte set on the final
// byte of a region. The pattern, its compare mask, its length and the base
// address are written beforehand through the APB-style port, registers at
// byte addresses 0, 8, 16, 24 and 32; pready is always high and a write
// lands at the access cycle.
// For each region the block gives one result word on the output channel
// (o_out_valid, i_out_ready, o_out_word): found with the address of the
// first match as soon as the byte that completes it arrives, or, if the
// region ends without a match, found clear with address zero.
// A result is registered and appears in the cycle after the word that causes it is accepted.
// Throughput: one byte per cycle while o_in_ready is high; the window shift and the parallel masked
// compare of all pattern bytes finish in the cycle the byte is accepted.
// A pending result does not block input: a new word is taken whenever the
// result register is empty or is being read in the same cycle. Only when a
// result waits and the receiver holds i_out_ready low does o_in_ready drop.
// Reset clears the byte count, the match flag, the pending result and the
// configuration (pattern length returns to one).
`default_nettype none

module masked_byte_signature_scanner #(
    parameter int PATTERN_BYTES = mbss_pkg::PATTERN_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire mbss_pkg::t_in_word              i_in_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output mbss_pkg::t_out_word                  o_out_word,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mbss_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [mbss_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [mbss_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import mbss_pkg::*;

    t_cfg          cfg;
    t_match_result result;
    t_match_status status;
    logic          in_accept;
    logic          r_out_valid;
    t_out_word     r_out_word;

    mbss_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbss_matcher #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_matcher (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_in_word (i_in_word),
        .i_cfg     (cfg),
        .o_result  (result),
        .o_status  (status)
    );

    // The result register doubles as the skid stage between the two sides.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word <= result.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A not-found result always carries address zero.
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.found) |-> (o_out_word.match_address == 32'd0))
        else $error("not-found result with nonzero address");

    // The final byte of a region rearms the matcher.
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_word.last_byte)
            |=> (status.bytes_seen == 32'd0 && !status.reported))
        else $error("matcher not rearmed after final byte");

    // A match can only have been reported once at least one byte was seen.
    a_reported_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.reported |-> (status.bytes_seen != 32'd0))
        else $error("match flag set with empty byte count");

    // Once a region's match is reported, no further result comes in it.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && status.reported) |=> !o_out_valid)
        else $error("second result within one region");

endmodule

`default_nettype wire

### design/mbss_cfg_regs.sv
// Configuration register file of the masked byte signature scanner.
// APB-style write and read port over five registers; uses mbss_pkg.
`default_nettype none

module mbss_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mbss_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [mbss_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [mbss_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready,
    output mbss_pkg::t_cfg                       o_cfg
);
    import mbss_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_low_bytes  <= '0;
            r_cfg.pattern_high_bytes <= '0;
            r_cfg.compare_mask       <= '0;
            r_cfg.pattern_length     <= PATTERN_LEN_RESET;
            r_cfg.base_address       <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PATTERN_LOW:  r_cfg.pattern_low_bytes  <= pwdata;
                REG_PATTERN_HIGH: r_cfg.pattern_high_bytes <= pwdata;
                REG_COMPARE_MASK: r_cfg.compare_mask       <= pwdata[15:0];
                REG_PATTERN_LEN:  r_cfg.pattern_length     <= pwdata[4:0];
                REG_BASE_ADDRESS: r_cfg.base_address       <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PATTERN_LOW:  prdata = r_cfg.pattern_low_bytes;
            REG_PATTERN_HIGH: prdata = r_cfg.pattern_high_bytes;
            REG_COMPARE_MASK: prdata = {48'd0, r_cfg.compare_mask};
            REG_PATTERN_LEN:  prdata = {59'd0, r_cfg.pattern_length};
            REG_BASE_ADDRESS: prdata = {32'd0, r_cfg.base_address};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/mbss_matcher.sv
// Byte window, region byte count and masked parallel compare.
// Produces at most one result per accepted word; uses mbss_pkg.
`default_nettype none

module mbss_matcher #(
    parameter int PATTERN_BYTES = mbss_pkg::PATTERN_BYTES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_accept,
    input  wire mbss_pkg::t_in_word      i_in_word,
    input  wire mbss_pkg::t_cfg          i_cfg,
    output mbss_pkg::t_match_result      o_result,
    output mbss_pkg::t_match_status      o_status
);
    import mbss_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_BYTES + 1);
    localparam int IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    t_byte         r_window [PATTERN_BYTES];
    t_byte         n_window [PATTERN_BYTES];
    logic [31:0]   r_bytes_seen;
    logic [31:0]   n_bytes_seen;
    logic          r_reported;
    logic [LEN_W-1:0] len_eff;
    logic [127:0]  pattern;
    logic          window_hit;
    logic          hit;
    logic [LEN_W-1:0] age;

    // Clamp the programmed length into 1 .. PATTERN_BYTES.
    always_comb begin
        if (i_cfg.pattern_length == 5'd0) begin
            len_eff = LEN_W'(1);
        end else if (i_cfg.pattern_length > 5'(PATTERN_BYTES)) begin
            len_eff = LEN_W'(PATTERN_BYTES);
        end else begin
            len_eff = i_cfg.pattern_length[LEN_W-1:0];
        end
    end

    assign pattern = {i_cfg.pattern_high_bytes, i_cfg.pattern_low_bytes};

    // Window as it stands once the incoming byte is shifted in; entry 0 is newest.
    always_comb begin
        n_window[0] = i_in_word.data_byte;
        for (int i = 1; i < PATTERN_BYTES; i++) begin
            n_window[i] = r_window[i-1];
        end
    end

    assign n_bytes_seen = (r_bytes_seen == 32'hFFFF_FFFF) ? r_bytes_seen
                                                          : r_bytes_seen + 32'd1;

    // Pattern byte k lines up with the byte that arrived len-1-k words ago.
    always_comb begin
        window_hit = 1'b1;
        age        = '0;
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            age = len_eff - LEN_W'(1) - LEN_W'(k);
            if ((LEN_W'(k) < len_eff) && i_cfg.compare_mask[k]
                && (n_window[age[IDX_W-1:0]] != pattern[8*k +: 8])) begin
                window_hit = 1'b0;
            end
        end
    end

    assign hit = !r_reported && (n_bytes_seen >= 32'(len_eff)) && window_hit;

    always_comb begin
        o_result.valid = hit || (i_in_word.last_byte && !r_reported);
        o_result.word.found = hit;
        o_result.word.match_address = hit
            ? i_cfg.base_address + n_bytes_seen - 32'(len_eff) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_reported   <= 1'b0;
        end else if (i_accept) begin
            if (i_in_word.last_byte) begin
                r_bytes_seen <= '0;
                r_reported   <= 1'b0;
            end else begin
                r_bytes_seen <= n_bytes_seen;
                r_reported   <= r_reported || hit;
            end
        end
    end

    // Window contents are never compared before the byte count covers them.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_window <= n_window;
        end
    end

    assign o_status.bytes_seen = r_bytes_seen;
    assign o_status.reported   = r_reported;

endmodule

`default_nettype wire
